### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants shared by the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int MAX_BLOCKS = 16384;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int BIT_AW     = $clog2(WORD_BITS);
  localparam int IDX_W      = 14;
  localparam int CNT_W      = 15;
  localparam int CFG_DW     = 15;

  // operation codes
  localparam logic [2:0] OP_FORMAT  = 3'd0;
  localparam logic [2:0] OP_RESERVE = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_WRITE   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // configuration register indexes
  localparam logic CFG_TOTAL    = 1'b0;
  localparam logic CFG_RESERVED = 1'b1;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] block_index;
    logic             bit_value;
  } bba_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] block_number;
    logic             bit_read;
    logic [CNT_W-1:0] free_count;
    logic [1:0]       status;
  } bba_out_t;

endpackage

### rtl/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit block allocator over a one-bit-per-block occupancy map.
// ----------------------------------------------------------------------------
// The map sits in a 512 x 32 single-port-write RAM with a registered read.
// After reset the block runs a clearing pass over all 512 words during which
// in_ready stays low; configuration writes are taken at any time. Format
// rewrites every map word. Reserve reads one map word per cycle, lowest
// first, and stops at the first word with a free block below the total, or
// with no-space status at the last word below the total. Release and write
// bit do one read-modify-write of a single word; read bit reads one word. An
// out-of-range index, an unused op code or a reserve with a zero count goes
// straight to the result. The RAM port is the limit. One item is in work at a
// time; the result sits in an output register, and the next item is taken
// once it has been loaded there.
module block_bitmap_allocator
  import bba_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bba_in_t         in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bba_out_t        out_data,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_SCAN,
    S_RD,
    S_MOD,
    S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WORD_AW-1:0]     fill_addr_r, fill_addr_nxt;
  logic [CNT_W-1:0]       fill_res_r, fill_res_nxt;
  logic                   fill_rpt_r, fill_rpt_nxt;
  logic [WORD_AW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [WORD_AW-1:0]     chk_w_r, chk_w_nxt;
  logic                   chk_vld_r, chk_vld_nxt;
  logic [2:0]             op_r, op_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   val_r, val_nxt;
  logic [CNT_W-1:0]       free_r, free_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic [CNT_W-1:0]       resv_r, resv_nxt;
  logic [IDX_W-1:0]       blk_r, blk_nxt;
  logic                   rd_r, rd_nxt;
  logic [1:0]             sts_r, sts_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bba_out_t               out_data_r, out_data_nxt;

  // map RAM
  logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0]   rdata_r;
  logic                   mem_we;
  logic [WORD_AW-1:0]     mem_wa;
  logic [WORD_BITS-1:0]   mem_wd;
  logic [WORD_AW-1:0]     mem_ra;

  logic [CNT_W-1:0]       eff_total;
  logic [CNT_W-1:0]       eff_res;
  logic [CNT_W-1:0]       chk_base;
  logic [CNT_W-1:0]       chk_end;
  logic [CNT_W-1:0]       chk_lim;
  logic [WORD_BITS-1:0]   vmask;
  logic [WORD_BITS-1:0]   fvec;
  logic [BIT_AW-1:0]      fbit;
  logic                   found;
  logic [CNT_W-1:0]       fbase;
  logic [CNT_W-1:0]       fdiff;
  logic [WORD_BITS-1:0]   fill_word;
  logic [BIT_AW-1:0]      idx_bit;
  logic [WORD_AW-1:0]     idx_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rdata_r <= map_mem[mem_ra];
  end

  assign eff_total = (total_r > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_r;
  assign eff_res   = (resv_r > eff_total) ? eff_total : resv_r;
  assign idx_bit   = idx_r[BIT_AW-1:0];
  assign idx_word  = idx_r[IDX_W-1:BIT_AW];

  // scan: blocks of the checked word that lie below the total
  assign chk_base = CNT_W'({chk_w_r, BIT_AW'(0)});
  assign chk_end  = chk_base + CNT_W'(WORD_BITS);
  assign chk_lim  = (eff_total > chk_base) ? (eff_total - chk_base) : '0;

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      vmask[b] = CNT_W'(b) < chk_lim;
    end
  end

  assign fvec  = ~rdata_r & vmask;
  assign found = |fvec;

  // lowest free bit
  always_comb begin
    fbit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (fvec[b]) begin
        fbit = BIT_AW'(b);
      end
    end
  end

  // format pattern: leading reserved blocks set
  assign fbase = CNT_W'({fill_addr_r, BIT_AW'(0)});
  assign fdiff = fill_res_r - fbase;

  always_comb begin
    if (fill_res_r >= fbase + CNT_W'(WORD_BITS)) begin
      fill_word = '1;
    end else if (fill_res_r > fbase) begin
      fill_word = (WORD_BITS'(1) << fdiff[BIT_AW-1:0]) - WORD_BITS'(1);
    end else begin
      fill_word = '0;
    end
  end

  assign mem_ra = (state_r == S_SCAN) ? scan_addr_r : idx_word;

  always_comb begin
    state_nxt     = state_r;
    fill_addr_nxt = fill_addr_r;
    fill_res_nxt  = fill_res_r;
    fill_rpt_nxt  = fill_rpt_r;
    scan_addr_nxt = scan_addr_r;
    chk_w_nxt     = chk_w_r;
    chk_vld_nxt   = chk_vld_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    free_nxt      = free_r;
    total_nxt     = total_r;
    resv_nxt      = resv_r;
    blk_nxt       = blk_r;
    rd_nxt        = rd_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = fill_addr_r;
    mem_wd        = fill_word;
    in_ready      = 1'b0;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TOTAL:    total_nxt = cfg_wdata[CNT_W-1:0];
        CFG_RESERVED: resv_nxt  = cfg_wdata[CNT_W-1:0];
        default:      ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt  = in_data.op;
          idx_nxt = in_data.block_index;
          val_nxt = in_data.bit_value;
          blk_nxt = '0;
          rd_nxt  = 1'b0;
          sts_nxt = ST_OK;
          case (in_data.op)
            OP_FORMAT: begin
              fill_addr_nxt = '0;
              fill_res_nxt  = eff_res;
              fill_rpt_nxt  = 1'b1;
              free_nxt      = eff_total - eff_res;
              state_nxt     = S_FILL;
            end
            OP_RESERVE: begin
              if (free_r == '0) begin
                sts_nxt   = ST_NO_SPACE;
                state_nxt = S_DONE;
              end else begin
                scan_addr_nxt = '0;
                chk_vld_nxt   = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            OP_RELEASE, OP_READ, OP_WRITE: begin
              if (CNT_W'(in_data.block_index) >= eff_total) begin
                sts_nxt   = ST_RANGE;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_FILL: begin
        mem_we        = 1'b1;
        fill_addr_nxt = fill_addr_r + WORD_AW'(1);
        if (fill_addr_r == WORD_AW'(MAP_WORDS - 1)) begin
          state_nxt = fill_rpt_r ? S_DONE : S_IDLE;
        end
      end

      // one word read per cycle; the word read last cycle is checked here
      S_SCAN: begin
        scan_addr_nxt = scan_addr_r + WORD_AW'(1);
        chk_w_nxt     = scan_addr_r;
        chk_vld_nxt   = 1'b1;
        if (chk_vld_r) begin
          if (found) begin
            mem_we    = 1'b1;
            mem_wa    = chk_w_r;
            mem_wd    = rdata_r | (WORD_BITS'(1) << fbit);
            free_nxt  = free_r - CNT_W'(1);
            blk_nxt   = {chk_w_r, fbit};
            state_nxt = S_DONE;
          end else if (chk_end >= eff_total || chk_w_r == WORD_AW'(MAP_WORDS - 1)) begin
            sts_nxt   = ST_NO_SPACE;
            state_nxt = S_DONE;
          end
        end
      end

      S_RD: begin
        state_nxt = S_MOD;
      end

      S_MOD: begin
        mem_wa = idx_word;
        case (op_r)
          OP_RELEASE: begin
            mem_we   = 1'b1;
            mem_wd   = rdata_r & ~(WORD_BITS'(1) << idx_bit);
            free_nxt = (free_r < eff_total) ? free_r + CNT_W'(1) : eff_total;
            blk_nxt  = idx_r;
          end
          OP_READ: begin
            rd_nxt = rdata_r[idx_bit];
          end
          default: begin
            mem_we = 1'b1;
            mem_wd = val_r ? (rdata_r | (WORD_BITS'(1) << idx_bit))
                           : (rdata_r & ~(WORD_BITS'(1) << idx_bit));
          end
        endcase
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.block_number = blk_r;
          out_data_nxt.bit_read     = rd_r;
          out_data_nxt.free_count   = free_r;
          out_data_nxt.status       = sts_r;
          state_nxt                 = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // clearing pass over the map after reset
      state_r     <= S_FILL;
      fill_addr_r <= '0;
      fill_res_r  <= '0;
      fill_rpt_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      free_r      <= '0;
      total_r     <= CNT_W'(MAX_BLOCKS);
      resv_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_res_r  <= fill_res_nxt;
      fill_rpt_r  <= fill_rpt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      resv_r      <= resv_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_addr_r <= scan_addr_nxt;
    chk_w_r     <= chk_w_nxt;
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    blk_r       <= blk_nxt;
    rd_r        <= rd_nxt;
    sts_r       <= sts_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for block_bitmap_allocator. A directed pass walks the empty map,
// format, count saturation, range errors and a map with no room. Random
// phases follow, each with a new total and reserved count, mostly a format
// and then mixed reserve/release/read/write traffic. A shadow of the map and
// the free count predicts every result. Results are checked in order as they
// transfer, with random gaps on the input side and random stalls on the
// output side.
// ----------------------------------------------------------------------------
module tb;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT  = 2_500_000;
  localparam int RANDOM_ITEMS = 950;
  localparam logic [2:0] OP_UNUSED_LO = OP_WRITE + 3'd1;
  localparam logic [2:0] OP_UNUSED_HI = 3'h7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bba_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bba_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_idx = CFG_TOTAL;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  block_bitmap_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the allocator
  bit                occ [MAX_BLOCKS];
  int                free_blocks = 0;
  logic [CFG_DW-1:0] cfg_total = CFG_DW'(MAX_BLOCKS);
  logic [CFG_DW-1:0] cfg_reserved = '0;
  int                taken [$];

  bba_out_t pending_results [$];
  bba_out_t want;
  int       mismatches = 0;
  int       cycles = 0;
  int       burst_left = 0;

  logic [7:0] ready_pat = 8'hFF;
  logic [2:0] ready_ptr = '0;
  int         ready_hold = 0;

  function automatic int eff_total();
    return (cfg_total > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_total);
  endfunction

  function automatic bba_in_t mk_item(logic [2:0] op, logic [IDX_W-1:0] idx, logic val);
    bba_in_t it;
    it.op = op;
    it.block_index = idx;
    it.bit_value = val;
    return it;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(int tot);
    if (tot > 0 && $urandom_range(0, 99) < 85) return IDX_W'($urandom_range(0, tot - 1));
    return IDX_W'($urandom);
  endfunction

  // Applies one operation to the shadow map and returns the result it gives.
  function automatic bba_out_t apply_op(bba_in_t item);
    bba_out_t r;
    int tot, res, n;
    tot = eff_total();
    r = '0;
    n = -1;
    case (item.op)
      OP_FORMAT: begin
        res = (cfg_reserved > tot) ? tot : int'(cfg_reserved);
        for (int i = 0; i < MAX_BLOCKS; i++) occ[i] = (i < res);
        free_blocks = tot - res;
        taken.delete();
      end
      OP_RESERVE: begin
        // a nonzero count does not promise a clear bit below the total
        if (free_blocks != 0)
          for (int i = 0; i < tot && n < 0; i++) if (!occ[i]) n = i;
        if (n < 0) begin
          r.status = ST_NO_SPACE;
        end else begin
          occ[n] = 1'b1;
          free_blocks--;
          r.block_number = IDX_W'(n);
          taken.push_back(n);
        end
      end
      OP_RELEASE, OP_READ, OP_WRITE: begin
        if (int'(item.block_index) >= tot) begin
          r.status = ST_RANGE;
        end else if (item.op == OP_RELEASE) begin
          occ[item.block_index] = 1'b0;
          free_blocks = (free_blocks < tot) ? free_blocks + 1 : tot;
          r.block_number = item.block_index;
        end else if (item.op == OP_READ) begin
          r.bit_read = occ[item.block_index];
        end else begin
          occ[item.block_index] = item.bit_value;
        end
      end
      default: ;
    endcase
    r.free_count = CNT_W'(free_blocks);
    r.status = r.status;
    return r;
  endfunction

  // Valid stays high across a burst; it drops only for a gap or in wait_idle.
  task automatic send_item(bba_in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(apply_op(item));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_config(logic [CFG_DW-1:0] total, logic [CFG_DW-1:0] reserved);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_TOTAL;
    cfg_wdata <= total;
    @(posedge clk);
    cfg_total = total;
    cfg_idx <= CFG_RESERVED;
    cfg_wdata <= reserved;
    @(posedge clk);
    cfg_reserved = reserved;
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // fresh map after reset: count is zero, nothing formatted yet
  task automatic test_empty_map();
    send_item(mk_item(OP_RESERVE, '0, 1'b0));
    send_item(mk_item(OP_READ, '1, 1'b0));
    send_item(mk_item(OP_WRITE, '1, 1'b1));
    send_item(mk_item(OP_READ, '1, 1'b0));
    send_item(mk_item(OP_RELEASE, '1, 1'b0));
    send_item(mk_item(OP_UNUSED_LO, '1, 1'b1));
    send_item(mk_item(OP_UNUSED_HI, '0, 1'b0));
  endtask

  task automatic test_format_saturation();
    send_item(mk_item(OP_FORMAT, '0, 1'b0));
    send_item(mk_item(OP_RESERVE, '0, 1'b0));
    send_item(mk_item(OP_RELEASE, '0, 1'b0));
    send_item(mk_item(OP_RELEASE, '0, 1'b0));
    send_item(mk_item(OP_WRITE, '1, 1'b1));
  endtask

  task automatic test_range_and_full();
    wait_idle();
    set_config(CFG_DW'(40), CFG_DW'(38));
    send_item(mk_item(OP_FORMAT, '0, 1'b0));
    send_item(mk_item(OP_WRITE, IDX_W'(38), 1'b1));
    send_item(mk_item(OP_WRITE, IDX_W'(39), 1'b1));
    send_item(mk_item(OP_RESERVE, '0, 1'b0));
    send_item(mk_item(OP_READ, IDX_W'(40), 1'b0));
    send_item(mk_item(OP_RELEASE, '1, 1'b0));
    send_item(mk_item(OP_WRITE, IDX_W'(40), 1'b1));
    wait_idle();
    // both registers above the map size clamp to the whole map
    set_config('1, '1);
    send_item(mk_item(OP_FORMAT, '0, 1'b0));
    send_item(mk_item(OP_RESERVE, '0, 1'b0));
    wait_idle();
    set_config('0, '0);
    send_item(mk_item(OP_FORMAT, '0, 1'b0));
    send_item(mk_item(OP_READ, '0, 1'b0));
    send_item(mk_item(OP_RESERVE, '0, 1'b0));
  endtask

  task automatic test_random_traffic();
    logic [2:0] idx_ops [3] = '{OP_RELEASE, OP_READ, OP_WRITE};
    logic [CFG_DW-1:0] t, r;
    logic [IDX_W-1:0] idx;
    bba_in_t it;
    int counted, tot, len, pick, k;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       t = CFG_DW'(MAX_BLOCKS);
        1:       t = CFG_DW'($urandom_range(1, 32767));
        2:       t = CFG_DW'($urandom_range(0, 3));
        default: t = CFG_DW'($urandom_range(1, 160));
      endcase
      tot = (t > MAX_BLOCKS) ? MAX_BLOCKS : int'(t);
      case ($urandom_range(0, 5))
        0:       r = '0;
        1:       r = CFG_DW'($urandom_range(0, 32767));
        2:       r = CFG_DW'((tot > 2) ? tot - $urandom_range(0, 2) : tot);
        default: r = CFG_DW'($urandom_range(0, tot / 2));
      endcase
      set_config(t, r);
      // some phases keep the old map under the new total
      if ($urandom_range(0, 3) != 0) begin
        send_item(mk_item(OP_FORMAT, pick_index(tot), 1'($urandom)));
        counted++;
      end
      len = $urandom_range(15, 60);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          it = mk_item(OP_RESERVE, IDX_W'($urandom), 1'($urandom));
        end else if (pick < 65) begin
          if (taken.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, taken.size() - 1);
            idx = IDX_W'(taken[k]);
            taken.delete(k);
          end else begin
            idx = pick_index(tot);
          end
          it = mk_item(OP_RELEASE, idx, 1'($urandom));
        end else if (pick < 80) begin
          if (taken.size() != 0 && $urandom_range(0, 1) == 0)
            idx = IDX_W'(taken[$urandom_range(0, taken.size() - 1)]);
          else
            idx = pick_index(tot);
          it = mk_item(OP_READ, idx, 1'($urandom));
        end else if (pick < 92) begin
          it = mk_item(OP_WRITE, pick_index(tot), 1'($urandom));
        end else if (pick < 95) begin
          it = mk_item(OP_FORMAT, IDX_W'($urandom), 1'($urandom));
        end else if (pick < 97) begin
          it = mk_item(3'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI))),
                       IDX_W'($urandom), 1'($urandom));
        end else begin
          if (tot < MAX_BLOCKS) idx = IDX_W'($urandom_range(tot, MAX_BLOCKS - 1));
          else idx = IDX_W'($urandom);
          it = mk_item(idx_ops[$urandom_range(0, 2)], idx, 1'($urandom));
        end
        send_item(it);
        if (it.op <= OP_WRITE) counted++;
      end
    end
  endtask

  // receiver stalls: a short pattern replayed, swapped now and then
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_hold <= $urandom_range(20, 80);
      ready_pat <= ($urandom_range(0, 2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    ready_ptr <= ready_ptr + 3'd1;
    out_ready <= ready_pat[ready_ptr];
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected: %p", $time, out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("block_number", want.block_number, out_data.block_number);
        check_field("bit_read", want.bit_read, out_data.bit_read);
        check_field("free_count", want.free_count, out_data.free_count);
        check_field("status", want.status, out_data.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_map();
    test_format_saturation();
    test_range_and_full();
    test_random_traffic();
    wait_idle();
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
